[sv/efi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package efi_pkg;

  // Iteration budget per point and the counter that walks it.
  localparam int MAX_ITERATIONS = 128;
  localparam int ITER_W         = (MAX_ITERATIONS > 2) ? $clog2(MAX_ITERATIONS) : 1;
  localparam int STEP_W         = 7;

  // Q8.24 data, full products and the working width of unsaturated sums.
  localparam int DATA_W  = 32;
  localparam int OPND_W  = 33;
  localparam int PROD_W  = 64;
  localparam int FRAC_W  = 24;
  localparam int ACC_W   = 48;
  localparam int LIMIT_W = 31;
  localparam int MODE_W  = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_SQUARE   = 3'd0,
    MODE_CUBE     = 3'd1,
    MODE_JULIA    = 3'd2,
    MODE_SHIP     = 3'd3,
    MODE_SQ_MIN_Z = 3'd4,
    MODE_CUBE_SQ  = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_RE_RE,
    MUL_IM_IM,
    MUL_RE_IM,
    MUL_AR_RE,
    MUL_AI_IM,
    MUL_AR_IM,
    MUL_AI_RE
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_RI,
    ST_ADD,
    ST_C0,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_C4,
    ST_UPD,
    ST_DONE
  } state_t;

  // Sequencer to datapath.
  typedef struct packed {
    mul_sel_t mul_sel;
    logic     ld_in;
    logic     cap_sqr;
    logic     cap_sqi;
    logic     cap_sum;
    logic     cap_cr0;
    logic     cap_cr1;
    logic     cap_ci0;
    logic     cap_ci1;
    logic     upd;
    logic     use_cube;
  } ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic mag_over;
    logic cube_map;
    logic pre_step;
  } stat_t;

  // Modes six and seven fall back to the plain square map.
  function automatic mode_t decode_mode(input logic [MODE_W-1:0] code);
    mode_t m;
    case (code)
      3'd1:    m = MODE_CUBE;
      3'd2:    m = MODE_JULIA;
      3'd3:    m = MODE_SHIP;
      3'd4:    m = MODE_SQ_MIN_Z;
      3'd5:    m = MODE_CUBE_SQ;
      default: m = MODE_SQUARE;
    endcase
    return m;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if ((&x[ACC_W-1:DATA_W-1]) || !(|x[ACC_W-1:DATA_W-1])) begin
      r = x[DATA_W-1:0];
    end else if (x[ACC_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Arithmetic shift of a full product gives the floor of product / 2^24.
  function automatic logic signed [ACC_W-1:0] floor_q(input logic signed [PROD_W-1:0] p);
    return ACC_W'($signed(p[PROD_W-1:FRAC_W]));
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_acc(input logic signed [DATA_W-1:0] x);
    return ACC_W'(x);
  endfunction

endpackage

`default_nettype wire

[sv/efi_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

module efi_mul (
  input  wire logic                                clk,
  input  wire logic signed [efi_pkg::OPND_W-1:0]   opnd_a,
  input  wire logic signed [efi_pkg::OPND_W-1:0]   opnd_b,
  output logic signed      [efi_pkg::PROD_W-1:0]   prod_r
);
  import efi_pkg::*;

  logic signed [2*OPND_W-1:0] full_prod;
  logic signed [PROD_W-1:0]   prod_nxt;

  // Operands never exceed 2^31 in magnitude, so the product fits 64 bits.
  assign full_prod = opnd_a * opnd_b;
  assign prod_nxt  = full_prod[PROD_W-1:0];

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire

[sv/efi_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module efi_dp (
  input  wire logic                                clk,
  input  wire efi_pkg::ctrl_t                      ctrl,
  output efi_pkg::stat_t                           stat,
  input  wire logic [efi_pkg::DATA_W-1:0]          point_re,
  input  wire logic [efi_pkg::DATA_W-1:0]          point_im,
  input  wire logic [efi_pkg::MODE_W-1:0]          cfg_mode,
  input  wire logic [efi_pkg::LIMIT_W-1:0]         cfg_limit,
  input  wire logic signed [efi_pkg::DATA_W-1:0]   cfg_julia
);
  import efi_pkg::*;

  mode_t mode;

  logic signed [DATA_W-1:0] re_r, re_nxt, im_r, im_nxt;
  logic signed [DATA_W-1:0] u_r, v_r;
  logic signed [PROD_W-1:0] sqr_r, sqi_r;
  logic signed [ACC_W-1:0]  sr_r, si_r, cr_r, ci_r;
  logic signed [ACC_W-1:0]  nr, ni;
  logic signed [DATA_W-1:0] ar, ai;
  logic signed [OPND_W-1:0] opnd_a, opnd_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  prod_fl;
  logic [PROD_W-1:0]        mag, limit_q;

  assign mode = decode_mode(cfg_mode);

  assign stat.cube_map = (mode == MODE_CUBE) || (mode == MODE_CUBE_SQ);
  assign stat.pre_step = (mode == MODE_CUBE_SQ);

  // Exact squared magnitude of the latest z against limit * 2^24.
  assign mag           = sqr_r + sqi_r;
  assign limit_q       = {{(PROD_W-LIMIT_W-FRAC_W){1'b0}}, cfg_limit, {FRAC_W{1'b0}}};
  assign stat.mag_over = mag > limit_q;

  assign ar      = sat32(sr_r);
  assign ai      = sat32(si_r);
  assign prod_fl = floor_q(prod_r);

  always_comb begin
    opnd_a = '0;
    opnd_b = '0;
    case (ctrl.mul_sel)
      MUL_RE_RE: begin
        opnd_a = OPND_W'(re_r);
        opnd_b = OPND_W'(re_r);
      end
      MUL_IM_IM: begin
        opnd_a = OPND_W'(im_r);
        opnd_b = OPND_W'(im_r);
      end
      MUL_RE_IM: begin
        opnd_a = OPND_W'(re_r);
        opnd_b = OPND_W'(im_r);
        // Burning ship folds both parts into the first quadrant first.
        if (mode == MODE_SHIP) begin
          if (re_r < 0) opnd_a = -OPND_W'(re_r);
          if (im_r < 0) opnd_b = -OPND_W'(im_r);
        end
      end
      MUL_AR_RE: begin
        opnd_a = OPND_W'(ar);
        opnd_b = OPND_W'(re_r);
      end
      MUL_AI_IM: begin
        opnd_a = OPND_W'(ai);
        opnd_b = OPND_W'(im_r);
      end
      MUL_AR_IM: begin
        opnd_a = OPND_W'(ar);
        opnd_b = OPND_W'(im_r);
      end
      MUL_AI_RE: begin
        opnd_a = OPND_W'(ai);
        opnd_b = OPND_W'(re_r);
      end
      default: begin
        opnd_a = '0;
        opnd_b = '0;
      end
    endcase
  end

  efi_mul u_mul (
    .clk    (clk),
    .opnd_a (opnd_a),
    .opnd_b (opnd_b),
    .prod_r (prod_r)
  );

  always_comb begin
    if (ctrl.use_cube) begin
      if (mode == MODE_CUBE_SQ) begin
        nr = cr_r - sr_r + ext_acc(u_r);
        ni = ci_r - si_r + ext_acc(v_r);
      end else begin
        nr = cr_r + ext_acc(u_r);
        ni = ci_r + ext_acc(v_r);
      end
    end else begin
      case (mode)
        MODE_JULIA: begin
          nr = sr_r + ext_acc(cfg_julia);
          ni = si_r + ext_acc(cfg_julia);
        end
        MODE_SQ_MIN_Z: begin
          nr = sr_r - ext_acc(re_r) + ext_acc(u_r);
          ni = si_r - ext_acc(im_r) + ext_acc(v_r);
        end
        default: begin
          nr = sr_r + ext_acc(u_r);
          ni = si_r + ext_acc(v_r);
        end
      endcase
    end
  end

  always_comb begin
    re_nxt = re_r;
    im_nxt = im_r;
    if (ctrl.ld_in) begin
      re_nxt = point_re;
      im_nxt = point_im;
    end else if (ctrl.upd) begin
      re_nxt = sat32(nr);
      im_nxt = sat32(ni);
    end
  end

  always_ff @(posedge clk) begin
    re_r <= re_nxt;
    im_r <= im_nxt;
    if (ctrl.ld_in) begin
      u_r <= point_re;
      v_r <= point_im;
    end
    if (ctrl.cap_sqr) sqr_r <= prod_r;
    if (ctrl.cap_sqi) sqi_r <= prod_r;
    if (ctrl.cap_sum) begin
      sr_r <= floor_q(sqr_r) - floor_q(sqi_r);
      si_r <= prod_fl <<< 1;
    end
    if (ctrl.cap_cr0) cr_r <= prod_fl;
    if (ctrl.cap_cr1) cr_r <= cr_r - prod_fl;
    if (ctrl.cap_ci0) ci_r <= prod_fl;
    if (ctrl.cap_ci1) ci_r <= ci_r + prod_fl;
  end

endmodule

`default_nettype wire

[sv/efi_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module efi_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_escaped,
  output logic [efi_pkg::STEP_W-1:0]         out_step,
  output efi_pkg::ctrl_t                     ctrl,
  input  wire efi_pkg::stat_t                stat
);
  import efi_pkg::*;

  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(MAX_ITERATIONS - 1);

  state_t            state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              chk_r, chk_nxt;
  logic              pre_r, pre_nxt;
  logic              res_esc_r, res_esc_nxt;
  logic [STEP_W-1:0] res_step_r, res_step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_esc_r;
  logic [STEP_W-1:0] out_step_r;
  logic              finish, out_free;
  logic [ITER_W+STEP_W-1:0] iter_wide;

  // Step index reported modulo 2^STEP_W.
  assign iter_wide = {{STEP_W{1'b0}}, iter_r};
  assign finish    = chk_r && (stat.mag_over || (iter_r == ITER_LAST));
  assign out_free  = !out_valid_r || out_ready;

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_escaped = out_esc_r;
  assign out_step    = out_step_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_SQ_RE;
      ST_SQ_RE: state_nxt = ST_SQ_IM;
      ST_SQ_IM: state_nxt = ST_RI;
      ST_RI:    state_nxt = ST_ADD;
      ST_ADD: begin
        if (finish) begin
          state_nxt = ST_DONE;
        end else if (stat.cube_map && !pre_r) begin
          state_nxt = ST_C0;
        end else begin
          state_nxt = ST_UPD;
        end
      end
      ST_C0:    state_nxt = ST_C1;
      ST_C1:    state_nxt = ST_C2;
      ST_C2:    state_nxt = ST_C3;
      ST_C3:    state_nxt = ST_C4;
      ST_C4:    state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_SQ_RE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath controls.
  always_comb begin
    ctrl          = '0;
    ctrl.mul_sel  = MUL_NONE;
    ctrl.use_cube = stat.cube_map && !pre_r;
    case (state_r)
      ST_IDLE:  ctrl.ld_in = in_valid;
      ST_SQ_RE: ctrl.mul_sel = MUL_RE_RE;
      ST_SQ_IM: begin
        ctrl.mul_sel = MUL_IM_IM;
        ctrl.cap_sqr = 1'b1;
      end
      ST_RI: begin
        ctrl.mul_sel = MUL_RE_IM;
        ctrl.cap_sqi = 1'b1;
      end
      ST_ADD:   ctrl.cap_sum = 1'b1;
      ST_C0:    ctrl.mul_sel = MUL_AR_RE;
      ST_C1: begin
        ctrl.mul_sel = MUL_AI_IM;
        ctrl.cap_cr0 = 1'b1;
      end
      ST_C2: begin
        ctrl.mul_sel = MUL_AR_IM;
        ctrl.cap_cr1 = 1'b1;
      end
      ST_C3: begin
        ctrl.mul_sel = MUL_AI_RE;
        ctrl.cap_ci0 = 1'b1;
      end
      ST_C4:    ctrl.cap_ci1 = 1'b1;
      ST_UPD:   ctrl.upd = 1'b1;
      default:  ctrl.mul_sel = MUL_NONE;
    endcase
  end

  // Iteration bookkeeping and result hand-off.
  always_comb begin
    iter_nxt      = iter_r;
    chk_nxt       = chk_r;
    pre_nxt       = pre_r;
    res_esc_nxt   = res_esc_r;
    res_step_nxt  = res_step_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          iter_nxt = '0;
          chk_nxt  = 1'b0;
          pre_nxt  = stat.pre_step;
        end
      end
      ST_ADD: begin
        if (finish) begin
          res_esc_nxt  = stat.mag_over;
          res_step_nxt = stat.mag_over ? iter_wide[STEP_W-1:0] : '0;
        end else if (chk_r) begin
          iter_nxt = iter_r + 1'b1;
        end
      end
      ST_UPD: begin
        // The mode five pre-step is never tested.
        chk_nxt = chk_r || !pre_r;
        pre_nxt = 1'b0;
      end
      ST_DONE: begin
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: iter_nxt = iter_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      iter_r      <= '0;
      chk_r       <= 1'b0;
      pre_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      iter_r      <= iter_nxt;
      chk_r       <= chk_nxt;
      pre_r       <= pre_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_esc_r  <= res_esc_nxt;
    res_step_r <= res_step_nxt;
    if (state_r == ST_DONE && out_free) begin
      out_esc_r  <= res_esc_r;
      out_step_r <= res_step_r;
    end
  end

endmodule

`default_nettype wire

[sv/escape_time_fractal_iterator_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                        Payload
// in_      slave      in_tvalid / in_tready            point_re, point_im (Q8.24)
// out_     master     out_tvalid / out_tready          escaped, escape_step
// cfg_     APB slave  psel, penable, pwrite, pready=1  fractal_mode, escape_limit,
//                                                     julia_constant
//
// One point is processed at a time on a single 33x33 multiplier that is reused
// for every product; that multiplier sets the rate. Loading is followed by the
// first squares; each quadratic iteration forms the squares and the cross
// product, sums them and updates z, and each cubic iteration adds four more
// products before the update; the result then moves to the output register.
// Mode five adds its square pre-step, and a bounded point runs all
// MAX_ITERATIONS steps.
// Reset is synchronous and active low; it idles the sequencer, empties the
// output register and restores the register defaults.
// A result that waits on out_tready holds the core in its done state; the next
// point is taken only once the result has moved into the output register.

module escape_time_fractal_iterator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,    // [31:0] point_re, [63:32] point_im
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,   // [0] escaped, [7:1] escape_step
  // Configuration port.
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import efi_pkg::*;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_JULIA = 2'd2;

  logic [MODE_W-1:0]        mode_r;
  logic [LIMIT_W-1:0]       limit_r;
  logic signed [DATA_W-1:0] julia_r;
  logic                     cfg_wr;
  logic [1:0]               reg_idx;

  ctrl_t             ctrl;
  stat_t             stat;
  logic              res_escaped;
  logic [STEP_W-1:0] res_step;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register file. Writes to the unused fourth slot are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_W'(0);
      limit_r <= LIMIT_W'(83886080);
      julia_r <= DATA_W'(5872026);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MODE:  mode_r  <= cfg_pwdata[MODE_W-1:0];
        REG_LIMIT: limit_r <= cfg_pwdata[LIMIT_W-1:0];
        REG_JULIA: julia_r <= cfg_pwdata[DATA_W-1:0];
        default:   mode_r  <= mode_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:  cfg_prdata = {{(32-MODE_W){1'b0}}, mode_r};
      REG_LIMIT: cfg_prdata = {{(32-LIMIT_W){1'b0}}, limit_r};
      REG_JULIA: cfg_prdata = julia_r;
      default:   cfg_prdata = '0;
    endcase
  end

  efi_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_escaped (res_escaped),
    .out_step    (res_step),
    .ctrl        (ctrl),
    .stat        (stat)
  );

  efi_dp u_dp (
    .clk       (clk),
    .ctrl      (ctrl),
    .stat      (stat),
    .point_re  (in_tdata[31:0]),
    .point_im  (in_tdata[63:32]),
    .cfg_mode  (mode_r),
    .cfg_limit (limit_r),
    .cfg_julia (julia_r)
  );

  assign out_tdata = {res_step, res_escaped};

endmodule

`default_nettype wire

[sv/efi_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module efi_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);

  // A result that is not taken keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Once a point is taken the core is busy with it.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("core ready right after taking a point");

  // No result can appear in the cycle after a point is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared right after a point was taken");

  // A bounded point reports step zero.
  a_bounded_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[7:1] == 7'd0)
    else $error("bounded point with nonzero step");

endmodule

bind escape_time_fractal_iterator_core efi_checker u_efi_checker (.*);

`default_nettype wire

[tb/sv/escape_time_fractal_iterator_core_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the escape-time fractal iterator core.
// A directed table runs first, then random register settings with sixty
// points each. Each accepted point gets its expected escape result from the
// table where typed, else from a local predictor. Every transfer on the
// result stream is checked, in order, against those expectations.
module escape_time_fractal_iterator_core_tb;
  import efi_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 40;
  localparam int HOLD_CYCLES     = 400;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int MAX_REPORTS     = 10;

  // Register map of the configuration port.
  typedef enum logic [3:0] {
    REG_MODE  = 4'h0,
    REG_LIMIT = 4'h4,
    REG_JULIA = 4'h8
  } reg_addr_t;

  // The two mode codes that the package leaves unnamed; the core treats
  // both as the plain square map.
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  // Handy Q8.24 constants.
  localparam logic [31:0] Q_ZERO    = 32'h0000_0000;
  localparam logic [31:0] Q_LSB     = 32'h0000_0001;
  localparam logic [31:0] Q_ONE     = 32'h0100_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hFF00_0000;
  localparam logic [31:0] Q_NEG_TWO = 32'hFE00_0000;
  localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN     = 32'h8000_0000;
  localparam logic [31:0] LIMIT_5   = 32'd83886080;
  localparam logic [31:0] LIMIT_4   = 32'd67108864;
  localparam logic [31:0] LIMIT_TOP = 32'h7FFF_FFFF;

  // Half-widths of the random point windows: 2.25 around the set, 0.5 near
  // the origin.
  localparam int unsigned WIDE_SPAN = 32'd37748736;
  localparam int unsigned NEAR_SPAN = 32'd8388608;

  typedef struct packed {
    logic       escaped;
    logic [6:0] step;
  } escape_result_t;

  typedef enum logic {
    ROW_POINT,
    ROW_WRITE
  } row_kind_t;

  typedef struct {
    row_kind_t      kind;
    reg_addr_t      addr;
    logic [31:0]    wval;
    logic [31:0]    pre;
    logic [31:0]    pim;
    bit             typed;
    escape_result_t result;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // [31:0] point_re, [63:32] point_im
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [0] escaped, [7:1] escape_step
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Local copy of the three registers, as they stand after reset.
  logic [MODE_W-1:0]  mode_shadow  = 3'd0;
  logic [LIMIT_W-1:0] limit_shadow = 31'd83886080;
  logic [31:0]        julia_shadow = 32'd5872026;

  escape_result_t pending_escapes[$];

  int  mismatch_count = 0;
  int  points_sent    = 0;
  int  escaped_seen   = 0;
  int  bounded_seen   = 0;
  int  settings_used  = 1;
  bit  calm           = 1'b0;  // no idling on either side while set
  bit  hold_req       = 1'b0;  // asks the receiver for one long hold-off

  escape_time_fractal_iterator_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #(CLK_HALF) clk = ~clk;

  // Safety net: far beyond the slowest legal run, even if every point stays
  // bounded in a cubic mode.
  initial begin
    #(40_000_000);
    $display("Timeout: %0d results still outstanding.", pending_escapes.size());
    $display("** escape_time_fractal_iterator_core: FAILED **");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH %s", $realtime, what);
    end
  endtask

  // Q8.24 product, rounded toward minus infinity.
  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> FRAC_W;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Runs the selected map on one point with the current register copy and
  // returns the step at which the squared magnitude first passes the limit.
  function automatic escape_result_t predict_escape(input logic [31:0] re_in,
                                                    input logic [31:0] im_in);
    escape_result_t res;
    mode_t m;
    longint cre, cim, k, zr, zi, sr, si, ar, ai, xr, xi, nr, ni;
    longint unsigned mag, lim;
    int i;
    bit hit;
    cre = $signed(re_in);
    cim = $signed(im_in);
    k   = $signed(julia_shadow);
    zr  = cre;
    zi  = cim;
    lim = 64'(limit_shadow) << FRAC_W;
    res = '0;
    hit = 1'b0;
    if (mode_shadow > MODE_CUBE_SQ) m = MODE_SQUARE;
    else m = mode_t'(mode_shadow);

    // The cubic-minus-square map starts with one untested square step.
    if (m == MODE_CUBE_SQ) begin
      sr = qmul(zr, zr) - qmul(zi, zi);
      si = 2 * qmul(zr, zi);
      zr = clamp32(sr + cre);
      zi = clamp32(si + cim);
    end

    for (i = 0; i < MAX_ITERATIONS && !hit; i++) begin
      sr = qmul(zr, zr) - qmul(zi, zi);
      if (m == MODE_SHIP) begin
        // Burning ship folds both parts positive before squaring.
        si = 2 * qmul((zr < 0) ? -zr : zr, (zi < 0) ? -zi : zi);
      end else begin
        si = 2 * qmul(zr, zi);
      end
      case (m)
        MODE_CUBE, MODE_CUBE_SQ: begin
          ar = clamp32(sr);
          ai = clamp32(si);
          xr = qmul(ar, zr) - qmul(ai, zi);
          xi = qmul(ar, zi) + qmul(ai, zr);
          if (m == MODE_CUBE) begin
            nr = xr + cre;
            ni = xi + cim;
          end else begin
            nr = xr - sr + cre;
            ni = xi - si + cim;
          end
        end
        MODE_JULIA: begin
          // The constant lands on both parts, not just the real one.
          nr = sr + k;
          ni = si + k;
        end
        MODE_SQ_MIN_Z: begin
          nr = sr - zr + cre;
          ni = si - zi + cim;
        end
        default: begin
          nr = sr + cre;
          ni = si + cim;
        end
      endcase
      zr  = clamp32(nr);
      zi  = clamp32(ni);
      mag = $unsigned(zr * zr) + $unsigned(zi * zi);
      if (mag > lim) begin
        hit         = 1'b1;
        res.escaped = 1'b1;
        res.step    = i[6:0];
      end
    end
    return res;
  endfunction

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic cfg_access(input bit wr, input reg_addr_t addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Stops offering points and waits for every outstanding result. Each
  // point yields exactly one result, so the core is idle afterwards.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_escapes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes one register while the core is idle and reads it back.
  task automatic program_reg(input reg_addr_t addr, input logic [31:0] value);
    logic [31:0] rd, want, mask;
    drain_results();
    cfg_access(1'b1, addr, value, rd);
    case (addr)
      REG_MODE: begin
        mode_shadow = value[MODE_W-1:0];
        mask = 32'h0000_0007;
      end
      REG_LIMIT: begin
        limit_shadow = value[LIMIT_W-1:0];
        mask = 32'h7FFF_FFFF;
      end
      default: begin
        julia_shadow = value;
        mask = 32'hFFFF_FFFF;
      end
    endcase
    want = value & mask;
    cfg_access(1'b0, addr, '0, rd);
    if ((rd & mask) !== want) begin
      flag_mismatch($sformatf("readback at 0x%0h: expected 0x%08h, got 0x%08h",
                              addr, want, rd & mask));
    end
  endtask

  // Offers one point, waits for its transfer and files its expected result.
  task automatic send_point(input logic [31:0] re, input logic [31:0] im,
                            input bit typed, input escape_result_t typed_res);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 32) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {im, re};
    do @(posedge clk); while (!in_tready);
    pending_escapes.push_back(typed ? typed_res : predict_escape(re, im));
    points_sent++;
  endtask

  function automatic dir_row_t row_point(input logic [31:0] re, input logic [31:0] im);
    dir_row_t r;
    r.kind   = ROW_POINT;
    r.addr   = REG_MODE;
    r.wval   = '0;
    r.pre    = re;
    r.pim    = im;
    r.typed  = 1'b0;
    r.result = '0;
    return r;
  endfunction

  function automatic dir_row_t row_known(input logic [31:0] re, input logic [31:0] im,
                                         input logic esc, input logic [6:0] step);
    dir_row_t r;
    r = row_point(re, im);
    r.typed          = 1'b1;
    r.result.escaped = esc;
    r.result.step    = step;
    return r;
  endfunction

  function automatic dir_row_t row_write(input reg_addr_t addr, input logic [31:0] value);
    dir_row_t r;
    r = row_point(Q_ZERO, Q_ZERO);
    r.kind = ROW_WRITE;
    r.addr = addr;
    r.wval = value;
    return r;
  endfunction

  // Result side: random back-pressure, plus one long hold-off on request
  // that lets the core fill up and stall its input.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 32);
      end
    end
  end

  // Every result transfer is compared field by field with the oldest
  // expectation.
  always @(posedge clk) begin
    escape_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (out_tdata[0]) escaped_seen++;
      else bounded_seen++;
      if (pending_escapes.size() == 0) begin
        flag_mismatch($sformatf("unexpected result 0x%02h", out_tdata));
      end else begin
        want = pending_escapes.pop_front();
        if (out_tdata[0] !== want.escaped) begin
          flag_mismatch($sformatf("escaped: expected %0b, got %0b",
                                  want.escaped, out_tdata[0]));
        end
        if (out_tdata[7:1] !== want.step) begin
          flag_mismatch($sformatf("escape_step: expected %0d, got %0d",
                                  want.step, out_tdata[7:1]));
        end
      end
    end
  end

  initial begin
    dir_row_t dir_tab[$];
    dir_row_t row;
    int idx, phase, n, sel;
    logic [31:0] re, im, lim_val, julia_val;

    // Directed part. Rows with a typed result are the ones that can be
    // worked out by hand: fixed points, short cycles, instant saturation.
    // Register defaults first: mode square, limit 5.0, constant 0.35.
    dir_tab.push_back(row_known(Q_ZERO, Q_ZERO, 1'b0, 7'd0));
    dir_tab.push_back(row_known(Q_MAX, Q_MAX, 1'b1, 7'd0));
    dir_tab.push_back(row_known(Q_MIN, Q_MIN, 1'b1, 7'd0));
    dir_tab.push_back(row_known(Q_MIN, Q_ZERO, 1'b1, 7'd0));
    dir_tab.push_back(row_known(Q_NEG_ONE, Q_ZERO, 1'b0, 7'd0));  // cycles -1, 0
    dir_tab.push_back(row_known(Q_NEG_TWO, Q_ZERO, 1'b0, 7'd0));  // sits at 2
    dir_tab.push_back(row_known(Q_ONE, Q_ZERO, 1'b1, 7'd1));      // 2 then 5
    dir_tab.push_back(row_known(Q_ZERO, Q_ONE, 1'b0, 7'd0));      // cycles -1+i, -i
    dir_tab.push_back(row_point(32'h0040_0000, 32'h0080_0000));
    dir_tab.push_back(row_write(REG_MODE, MODE_CUBE));
    dir_tab.push_back(row_known(Q_ZERO, Q_ZERO, 1'b0, 7'd0));
    dir_tab.push_back(row_point(32'h004C_CCCD, 32'h0080_0000));
    dir_tab.push_back(row_write(REG_MODE, MODE_JULIA));
    dir_tab.push_back(row_point(Q_ZERO, Q_ZERO));
    dir_tab.push_back(row_point(32'hFE80_0000, 32'h0033_3333));
    dir_tab.push_back(row_write(REG_JULIA, Q_MIN));
    dir_tab.push_back(row_known(Q_ZERO, Q_ZERO, 1'b1, 7'd0));
    dir_tab.push_back(row_write(REG_JULIA, Q_MAX));
    dir_tab.push_back(row_point(32'h0080_0000, 32'h0080_0000));
    // Burning ship near its well-known antenna, then a saturating corner.
    dir_tab.push_back(row_write(REG_MODE, MODE_SHIP));
    dir_tab.push_back(row_point(32'hFE40_0000, 32'hFFF8_51EC));
    dir_tab.push_back(row_known(Q_MIN, Q_MAX, 1'b1, 7'd0));
    dir_tab.push_back(row_write(REG_MODE, MODE_SQ_MIN_Z));
    dir_tab.push_back(row_known(Q_ZERO, Q_ZERO, 1'b0, 7'd0));
    dir_tab.push_back(row_point(32'h0080_0000, 32'hFF80_0000));
    dir_tab.push_back(row_write(REG_MODE, MODE_CUBE_SQ));
    dir_tab.push_back(row_known(Q_ZERO, Q_ZERO, 1'b0, 7'd0));
    dir_tab.push_back(row_point(32'hFF80_0000, 32'h0099_999A));
    // Undefined mode codes must behave like the square map.
    dir_tab.push_back(row_write(REG_MODE, MODE_SPARE6));
    dir_tab.push_back(row_known(Q_ONE, Q_ZERO, 1'b1, 7'd1));
    dir_tab.push_back(row_write(REG_MODE, MODE_SPARE7));
    dir_tab.push_back(row_known(Q_NEG_ONE, Q_ZERO, 1'b0, 7'd0));
    // A zero limit: only the origin survives; one LSB escapes at once.
    dir_tab.push_back(row_write(REG_LIMIT, Q_ZERO));
    dir_tab.push_back(row_known(Q_ZERO, Q_ZERO, 1'b0, 7'd0));
    dir_tab.push_back(row_known(Q_LSB, Q_ZERO, 1'b1, 7'd0));
    dir_tab.push_back(row_write(REG_LIMIT, LIMIT_TOP));
    dir_tab.push_back(row_point(Q_MAX, Q_MAX));

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    for (idx = 0; idx < dir_tab.size(); idx++) begin
      row = dir_tab[idx];
      if (row.kind == ROW_WRITE) begin
        program_reg(row.addr, row.wval);
        settings_used++;
      end else begin
        send_point(row.pre, row.pim, row.typed, row.result);
      end
    end

    // Random part. Each phase visits one mode code in turn (the two spare
    // codes included) with a random limit and Julia constant. Most points
    // fall in the two windows around the set and the origin so that many run
    // deep or stay bounded; the rest, full-range noise, escape almost at once.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       lim_val = Q_ZERO;
        1:       lim_val = LIMIT_TOP;
        2, 3:    lim_val = LIMIT_4;
        4, 5:    lim_val = LIMIT_5;
        default: lim_val = $urandom_range(32'h0100_0000, 32'h1000_0000);
      endcase
      if ($urandom_range(0, 3) == 0) julia_val = $urandom();
      else julia_val = $urandom_range(0, 2 * Q_ONE) - Q_ONE;
      program_reg(REG_MODE, 32'(phase % 8));
      program_reg(REG_LIMIT, lim_val);
      program_reg(REG_JULIA, julia_val);
      settings_used++;

      // One phase runs with no idling at all; another starts with a long
      // receiver hold-off while points keep coming.
      calm = (phase == 3);
      if (phase == 2) hold_req = 1'b1;

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          re = $urandom_range(0, 2 * WIDE_SPAN) - WIDE_SPAN;
          im = $urandom_range(0, 2 * WIDE_SPAN) - WIDE_SPAN;
        end else if (sel < 65) begin
          re = $urandom_range(0, 2 * NEAR_SPAN) - NEAR_SPAN;
          im = $urandom_range(0, 2 * NEAR_SPAN) - NEAR_SPAN;
        end else begin
          re = $urandom();
          im = $urandom();
        end
        send_point(re, im, 1'b0, '0);
      end
      calm = 1'b0;
    end

    // Let everything come out, then watch a little longer for strays.
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_escapes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_escapes.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", pending_escapes.size()));
    end

    $display("Ran %0d points over %0d register settings and all eight mode codes.",
             points_sent, settings_used);
    $display("Results: %0d escaped, %0d bounded; %0d mismatches.",
             escaped_seen, bounded_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** escape_time_fractal_iterator_core: PASSED **");
    end else begin
      $display("** escape_time_fractal_iterator_core: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
sv/efi_pkg.sv
sv/efi_mul.sv
sv/efi_dp.sv
sv/efi_ctrl.sv
sv/escape_time_fractal_iterator_core.sv
sv/efi_checker.sv
tb/sv/escape_time_fractal_iterator_core_tb.sv
